### rtl/core/subset_sum_reachable_table_macros.svh
// Assertion macros for the subset sum reachable table block
`ifndef SUBSET_SUM_REACHABLE_TABLE_MACROS_SVH
`define SUBSET_SUM_REACHABLE_TABLE_MACROS_SVH
// assert that a implies b in the same cycle
`define SSR_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b in the next cycle
`define SSR_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

### rtl/core/ssrt_pkg.sv
// Package with sizes and state encoding for the subset sum reachable table block
package ssrt_pkg;
	localparam int MAX_ITEMS = 32;
	localparam int TABLE_SIZE = 4096;
	localparam int TW = $clog2(TABLE_SIZE);
	localparam int FW = $clog2(TABLE_SIZE + 1);
	localparam int NW = $clog2(MAX_ITEMS + 1);
	localparam int WW = $clog2(MAX_ITEMS);
	localparam int SW = 18;
	localparam int RW = 17;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_FREAD,
		ST_FEVAL,
		ST_FRONT,
		ST_MARK,
		ST_SCAN,
		ST_BACK_RD,
		ST_BACK_CHK,
		ST_EMIT
	} state_t;
endpackage

### rtl/core/subset_sum_reachable_table.sv
// Top level of the subset sum reachable table block
//  channel | ports                                                 | direction
//  request | start busy weight last_item                           | in (busy out)
//  config  | capacity_we capacity_wdata                            | in
//  result  | result_valid item_index selected best_sum last_result | out
// A non-final request is taken without leaving the idle state and busy stays low.
// A final request runs a solve: the tables are cleared; per item a closing step and, per frontier
// entry, a read and an evaluation if already retired, plus a frontier write if it tries to extend,
// plus marking for each remaining item if it retires now; a scan of the table entries from
// capacity down; backtrack steps of a read and a check; then one result per cycle for each item.
// Reset is asynchronous and clears the registers, not the tables; results cannot be stalled.
module subset_sum_reachable_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] weight,
	input  logic        last_item,
	input  logic        capacity_we,
	input  logic [11:0] capacity_wdata,
	output logic        result_valid,
	output logic [5:0]  item_index,
	output logic        selected,
	output logic [11:0] best_sum,
	output logic        last_result
);
	import ssrt_pkg::*;

	state_t state_q, state_d;
	logic [11:0] cap_reg_q, cap_q;
	logic [11:0] wmem [MAX_ITEMS];
	logic [NW-1:0] tab [TABLE_SIZE];
	logic [13:0] fr [TABLE_SIZE];
	logic [MAX_ITEMS:1] chosen_q;
	logic [NW-1:0] n_q, i_q, k_q, out_q;
	logic [RW-1:0] tot_q, rem_q;
	logic [FW-1:0] j_q, cnt_q, end_q;
	logic [TW-1:0] addr_q;
	logic [SW-1:0] nw_q;
	logic [11:0] best_q, s_q;
	logic [13:0] pos_q;
	logic fwd_q;
	logic [NW-1:0] tab_rd_q;
	logic [13:0] fr_rd_q;

	logic accept, w_we, tab_we, fr_we;
	logic [TW-1:0] tab_waddr, tab_raddr, fr_waddr, fr_raddr;
	logic [NW-1:0] tab_wdata;
	logic [13:0] fr_wdata;
	logic [11:0] w_i, w_k, w_it;
	logic [SW-1:0] u_sum, cw_sum, nw_next;
	logic item_done, solve_done, fits, retired, mark_ok, front_ok, scan_hit, pos_pos, it_ok;
	logic [13:0] pos_next;

	assign busy = (state_q != ST_LOAD);
	assign accept = start && !busy;
	assign w_i = wmem[WW'(i_q - NW'(1))];
	assign w_k = wmem[k_q[WW-1:0]];
	assign w_it = wmem[WW'(tab_rd_q - NW'(1))];
	assign retired = fr_rd_q[13];
	assign u_sum = SW'(fr_rd_q[12:0]) + SW'(rem_q);
	assign cw_sum = SW'(fr_rd_q[12:0]) + SW'(w_i);
	assign nw_next = nw_q + SW'(w_k);
	assign fits = (u_sum <= SW'(cap_q));
	assign item_done = (j_q >= cnt_q);
	assign solve_done = (best_q == cap_q) || (i_q == n_q);
	assign mark_ok = (nw_q < SW'(TABLE_SIZE)) && (tab_rd_q == '0) && !fwd_q;
	assign front_ok = (nw_q <= SW'(cap_q)) && (tab_rd_q == '0);
	assign scan_hit = (tab_rd_q != '0) || (addr_q == '0);
	assign pos_pos = !pos_q[13] && (pos_q != '0);
	assign it_ok = (tab_rd_q != '0) && (tab_rd_q <= n_q);
	assign pos_next = (!it_ok || w_it == '0) ? pos_q - 14'd1 : pos_q - 14'(w_it);

	always_ff @(posedge clk) begin
		if (w_we) wmem[n_q[WW-1:0]] <= weight;
	end

	always_ff @(posedge clk) begin
		if (tab_we) tab[tab_waddr] <= tab_wdata;
		tab_rd_q <= tab[tab_raddr];
	end

	always_ff @(posedge clk) begin
		if (fr_we) fr[fr_waddr] <= fr_wdata;
		fr_rd_q <= fr[fr_raddr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (accept && last_item) state_d = ST_CLEAR;
			ST_CLEAR: if (addr_q == TW'(TABLE_SIZE - 1)) state_d = ST_FREAD;
			ST_FREAD: begin
				if (!item_done) state_d = ST_FEVAL;
				else if (solve_done) state_d = ST_SCAN;
			end
			ST_FEVAL: begin
				if (retired) state_d = ST_FREAD;
				else if (fits) state_d = ST_MARK;
				else state_d = ST_FRONT;
			end
			ST_FRONT: state_d = ST_FREAD;
			ST_MARK: if (k_q == n_q) state_d = ST_FREAD;
			ST_SCAN: if (scan_hit) state_d = ST_BACK_RD;
			ST_BACK_RD: state_d = pos_pos ? ST_BACK_CHK : ST_EMIT;
			ST_BACK_CHK: state_d = ST_BACK_RD;
			ST_EMIT: if (out_q == n_q) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		w_we = 1'b0;
		tab_we = 1'b0;
		tab_waddr = nw_q[TW-1:0];
		tab_wdata = '0;
		tab_raddr = '0;
		fr_we = 1'b0;
		fr_waddr = end_q[TW-1:0];
		fr_wdata = {1'b0, nw_q[12:0]};
		fr_raddr = j_q[TW-1:0];
		unique case (state_q)
			ST_LOAD: w_we = accept && (n_q < NW'(MAX_ITEMS));
			ST_CLEAR: begin
				tab_we = 1'b1;
				tab_waddr = addr_q;
				fr_we = 1'b1;
				fr_waddr = '0;
				fr_wdata = '0;
			end
			ST_FREAD: tab_raddr = TW'(cap_q);
			ST_FEVAL: begin
				tab_raddr = cw_sum[TW-1:0];
				if (!retired && fits) begin
					fr_we = 1'b1;
					fr_waddr = j_q[TW-1:0];
					fr_wdata = {1'b1, fr_rd_q[12:0]};
				end
			end
			ST_FRONT: begin
				tab_we = front_ok;
				tab_wdata = i_q;
				fr_we = front_ok && (end_q < FW'(TABLE_SIZE));
			end
			ST_MARK: begin
				tab_we = mark_ok;
				tab_wdata = k_q;
				tab_raddr = nw_next[TW-1:0];
			end
			ST_SCAN: tab_raddr = addr_q - TW'(1);
			ST_BACK_RD: tab_raddr = pos_q[TW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cap_reg_q <= '0;
			cap_q <= '0;
			chosen_q <= '0;
			n_q <= '0;
			i_q <= '0;
			k_q <= '0;
			out_q <= '0;
			tot_q <= '0;
			rem_q <= '0;
			j_q <= '0;
			cnt_q <= FW'(1);
			end_q <= FW'(1);
			addr_q <= '0;
			nw_q <= '0;
			best_q <= '0;
			s_q <= '0;
			pos_q <= '0;
			fwd_q <= 1'b0;
			result_valid <= 1'b0;
			item_index <= '0;
			selected <= 1'b0;
			best_sum <= '0;
			last_result <= 1'b0;
		end else begin
			state_q <= state_d;
			result_valid <= (state_q == ST_EMIT);
			if (capacity_we) cap_reg_q <= capacity_wdata;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (n_q < NW'(MAX_ITEMS)) begin
							n_q <= n_q + NW'(1);
							tot_q <= tot_q + RW'(weight);
						end
						if (last_item) begin
							addr_q <= '0;
							cap_q <= cap_reg_q;
						end
					end
				end
				ST_CLEAR: begin
					addr_q <= addr_q + TW'(1);
					chosen_q <= '0;
					cnt_q <= FW'(1);
					end_q <= FW'(1);
					j_q <= '0;
					i_q <= NW'(1);
					best_q <= '0;
					rem_q <= tot_q;
				end
				ST_FREAD: begin
					if (item_done) begin
						cnt_q <= end_q;
						j_q <= '0;
						if (solve_done) addr_q <= TW'(cap_q);
						else begin
							i_q <= i_q + NW'(1);
							rem_q <= rem_q - RW'(w_i);
						end
					end
				end
				ST_FEVAL: begin
					nw_q <= cw_sum;
					k_q <= i_q;
					fwd_q <= 1'b0;
					if (retired) j_q <= j_q + FW'(1);
					else if (fits && u_sum[11:0] > best_q) best_q <= u_sum[11:0];
				end
				ST_FRONT: begin
					if (front_ok && nw_q[11:0] > best_q) best_q <= nw_q[11:0];
					if (front_ok && end_q < FW'(TABLE_SIZE)) end_q <= end_q + FW'(1);
					j_q <= j_q + FW'(1);
				end
				ST_MARK: begin
					if (k_q == n_q) j_q <= j_q + FW'(1);
					else begin
						nw_q <= nw_next;
						k_q <= k_q + NW'(1);
						fwd_q <= mark_ok && (w_k == '0);
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						s_q <= addr_q;
						pos_q <= 14'(addr_q);
					end else addr_q <= addr_q - TW'(1);
				end
				ST_BACK_RD: if (!pos_pos) out_q <= NW'(1);
				ST_BACK_CHK: begin
					if (it_ok) chosen_q[tab_rd_q] <= 1'b1;
					pos_q <= pos_next;
				end
				ST_EMIT: begin
					item_index <= out_q;
					selected <= chosen_q[out_q];
					best_sum <= s_q;
					last_result <= (out_q == n_q);
					if (out_q == n_q) begin
						n_q <= '0;
						tot_q <= '0;
					end else out_q <= out_q + NW'(1);
				end
				default: ;
			endcase
		end
	end

	`include "subset_sum_reachable_table_macros.svh"
	`SSR_ASSERT_NEXT(a_final_busy, clk, arst_n, accept && last_item, busy)
	`SSR_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, n_q <= NW'(MAX_ITEMS))
	`SSR_ASSERT_IMP(a_index_nonzero, clk, arst_n, result_valid, item_index != '0)
	`SSR_ASSERT_IMP(a_idle_last, clk, arst_n, result_valid && !busy, last_result)
	`SSR_ASSERT_IMP(a_front_bound, clk, arst_n, 1'b1, end_q <= FW'(TABLE_SIZE))
endmodule
